[hw/rtl/ordered_list_insert_remove_search_core_macros.svh]
// Assertion macros for the ordered list core.
// Needs no other file; taken in by the top level.
`ifndef ORDERED_LIST_INSERT_REMOVE_SEARCH_CORE_MACROS_SVH
`define ORDERED_LIST_INSERT_REMOVE_SEARCH_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define OLIRS_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define OLIRS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`define OLIRS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define OLIRS_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define OLIRS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define OLIRS_ASSERT_SAME(lbl, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/olirs_pkg.sv]
// Shared types and constants of the ordered list core.
// Depends on nothing; used by olirs_cell and the top level.
package olirs_pkg;

   localparam int DEPTH_DEF = 32;
   localparam int WIDTH_DEF = 32;
   localparam int IDX_W     = 9;
   localparam int CMD_W     = 3;
   localparam int POS_W     = 8;
   localparam int VAL_W     = 32;
   localparam int STAT_W    = 2;
   localparam int CNT_OUT_W = 6;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND     = 3'd0,
      CMD_READ       = 3'd1,
      CMD_INSERT     = 3'd2,
      CMD_REMOVE     = 3'd3,
      CMD_REMOVE_ALL = 3'd4,
      CMD_CONTAINS   = 3'd5
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD  = 3'd0,
      CELL_OPEN  = 3'd1,
      CELL_CLOSE = 3'd2,
      CELL_MARK  = 3'd3,
      CELL_EVEN  = 3'd4,
      CELL_ODD   = 3'd5
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic [IDX_W-1:0]   mark;
      logic [IDX_W-1:0]   limit;
   } cell_ctrl_type;

endpackage

[hw/rtl/olirs_cell.sv]
// One storage cell of the list chain: holds an entry and a keep flag.
// Depends on olirs_pkg; instantiated once per position by the top level.
module olirs_cell #(
   parameter int INDEX = 0,
   parameter int WIDTH = olirs_pkg::WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  olirs_pkg::cell_ctrl_type ctrl,
   input  logic [WIDTH-1:0]        value,
   input  logic [WIDTH-1:0]        left_data,
   input  logic                    left_keep,
   input  logic [WIDTH-1:0]        right_data,
   input  logic                    right_keep,
   output logic [WIDTH-1:0]        data,
   output logic                    keep,
   output logic                    hit
);
   import olirs_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
   localparam bit IS_ODD = (INDEX % 2) == 1;

   logic [WIDTH-1:0] data_ff, data_in;
   logic             keep_ff, keep_in;
   logic             in_list;
   logic             lower;

   assign in_list = MY_IDX < ctrl.limit;
   assign hit     = in_list && (data_ff == value);
   assign data    = data_ff;
   assign keep    = keep_ff;
   assign lower   = (ctrl.op == CELL_ODD) ? IS_ODD : !IS_ODD;

   always_comb begin
      data_in = data_ff;
      keep_in = keep_ff;
      case (ctrl.op)
         CELL_HOLD: begin
         end
         CELL_OPEN: begin
            if (MY_IDX > ctrl.mark) begin
               data_in = left_data;
            end else if (MY_IDX == ctrl.mark) begin
               data_in = value;
            end
         end
         CELL_CLOSE: begin
            if (MY_IDX >= ctrl.mark) begin
               data_in = right_data;
            end
         end
         CELL_MARK: begin
            keep_in = in_list && (data_ff != value);
         end
         CELL_EVEN, CELL_ODD: begin
            if (lower) begin
               if (!keep_ff && right_keep) begin
                  data_in = right_data;
                  keep_in = 1'b1;
               end
            end else if (keep_ff && !left_keep) begin
               keep_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         keep_ff <= 1'b0;
      end else begin
         keep_ff <= keep_in;
      end
   end

endmodule

[hw/rtl/ordered_list_insert_remove_search_core.sv]
// Ordered list core: a chain of DEPTH cells packed from position 0.
// Depends on olirs_pkg, olirs_cell and the assertion macro header.
//
// Request beat: req_tuser carries the command, req_tdata the position and
// value. Response beat: one per request, with status, value read or
// removed, found flag and entry count after the command.
// Append, insert, read, remove and contains run as follows: the
// request register is loaded on acceptance, the cell chain shifts or
// compares in the next cycle, the result is registered, and it is then
// loaded into the response register while the next request is taken.
// In the chain step insert shifts later cells up by one, remove down by one.
// Remove all marks the cells to keep, those that do not match, and then
// runs DEPTH odd/even exchange passes over neighbouring cells, then recounts.
// Reset empties the list at once; entry storage is not cleared.
// If the receiver stalls, the response is held in its register; one more
// request is processed and then waits for the response slot to free.
`include "ordered_list_insert_remove_search_core_macros.svh"

module ordered_list_insert_remove_search_core #(
   parameter int DEPTH = olirs_pkg::DEPTH_DEF,
   parameter int WIDTH = olirs_pkg::WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // position [7:0], value_in [39:8]
   input  logic [olirs_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // command [2:0]
   input  logic [olirs_pkg::CMD_W-1:0]         req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // status [1:0], value_out [33:2], found [34], entry_count [40:35], zero [47:41]
   output logic [olirs_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import olirs_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   typedef enum logic [3:0] {
      S_IDLE    = 4'b0001,
      S_EXEC    = 4'b0010,
      S_COMPACT = 4'b0100,
      S_DONE    = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [WIDTH-1:0] val_ff, val_in;
   logic [CW-1:0]    fill_ff, fill_in;
   logic [CW-1:0]    pass_ff, pass_in;
   status_type       stat_ff, stat_in;
   logic [VAL_W-1:0] res_val_ff, res_val_in;
   logic             found_ff, found_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   cell_ctrl_type    ctrl;
   logic [WIDTH-1:0] data_w [DEPTH];
   logic [DEPTH:0]   keep_w;
   logic [DEPTH-1:0] hit_w;
   logic [CW-1:0]    kept_cnt;
   logic [CW-1:0]    place;
   logic [WIDTH-1:0] sel_data;
   logic             full;
   logic             beyond;
   logic             out_free;
   logic             req_take;

   assign full     = fill_ff == FULL_CNT;
   assign beyond   = PW'(pos_ff) >= PW'(fill_ff);
   assign sel_data = data_w[pos_ff[IW-1:0]];
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) || ((state_ff == S_DONE) && out_free);
   assign req_take   = req_tvalid && req_tready;
   assign keep_w[DEPTH] = 1'b0;

   always_comb begin
      kept_cnt = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (keep_w[i] && !keep_w[i+1]) begin
            kept_cnt = kept_cnt | CW'(i + 1);
         end
      end
   end

   generate
      for (genvar g = 0; g < DEPTH; g++) begin : g_cell
         logic [WIDTH-1:0] l_data, r_data;
         logic             l_keep, r_keep;
         if (g == 0) begin : g_first
            assign l_data = '0;
            assign l_keep = 1'b1;
         end else begin : g_mid_l
            assign l_data = data_w[g-1];
            assign l_keep = keep_w[g-1];
         end
         if (g == DEPTH - 1) begin : g_last
            assign r_data = '0;
            assign r_keep = 1'b0;
         end else begin : g_mid_r
            assign r_data = data_w[g+1];
            assign r_keep = keep_w[g+1];
         end
         olirs_cell #(
            .INDEX (g),
            .WIDTH (WIDTH)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .value      (val_ff),
            .left_data  (l_data),
            .left_keep  (l_keep),
            .right_data (r_data),
            .right_keep (r_keep),
            .data       (data_w[g]),
            .keep       (keep_w[g]),
            .hit        (hit_w[g])
         );
      end
   endgenerate

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      pos_in     = pos_ff;
      val_in     = val_ff;
      fill_in    = fill_ff;
      pass_in    = pass_ff;
      stat_in    = stat_ff;
      res_val_in = res_val_ff;
      found_in   = found_ff;
      place      = ((cmd_ff == CMD_APPEND) || beyond) ? fill_ff : CW'(pos_ff);
      ctrl.op    = CELL_HOLD;
      ctrl.mark  = IDX_W'(place);
      ctrl.limit = IDX_W'(fill_ff);
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
         end
         S_EXEC: begin
            stat_in    = ST_OK;
            res_val_in = '0;
            found_in   = 1'b0;
            state_in   = S_DONE;
            case (cmd_ff)
               CMD_APPEND, CMD_INSERT: begin
                  if (full) begin
                     stat_in = ST_FULL;
                  end else begin
                     ctrl.op = CELL_OPEN;
                     fill_in = fill_ff + 1'b1;
                  end
               end
               CMD_READ: begin
                  if (beyond) begin
                     stat_in = ST_RANGE;
                  end else begin
                     res_val_in = VAL_W'(sel_data);
                     found_in   = 1'b1;
                  end
               end
               CMD_REMOVE: begin
                  if (beyond) begin
                     stat_in = ST_RANGE;
                  end else begin
                     ctrl.op    = CELL_CLOSE;
                     res_val_in = VAL_W'(sel_data);
                     fill_in    = fill_ff - 1'b1;
                  end
               end
               CMD_REMOVE_ALL: begin
                  ctrl.op  = CELL_MARK;
                  pass_in  = '0;
                  state_in = S_COMPACT;
               end
               CMD_CONTAINS: begin
                  found_in = |hit_w;
               end
               default: begin
               end
            endcase
         end
         S_COMPACT: begin
            if (pass_ff == FULL_CNT) begin
               fill_in  = kept_cnt;
               state_in = S_DONE;
            end else begin
               ctrl.op = pass_ff[0] ? CELL_ODD : CELL_EVEN;
               pass_in = pass_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {(RSP_TDATA_W - 41)'(0), CNT_OUT_W'(fill_ff), found_ff,
                               res_val_ff, stat_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (req_take) begin
         cmd_in   = cmd_type'(req_tuser);
         pos_in   = req_tdata[POS_W-1:0];
         val_in   = WIDTH'(req_tdata[POS_W +: VAL_W]);
         state_in = S_EXEC;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      pos_ff      <= pos_in;
      val_ff      <= val_in;
      pass_ff     <= pass_in;
      stat_ff     <= stat_in;
      res_val_ff  <= res_val_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `OLIRS_ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= FULL_CNT)
   `OLIRS_ASSERT_NEXT(a_take_exec, clock, reset, req_take, state_ff == S_EXEC)
   `OLIRS_ASSERT_SAME(a_rsp_drop, clock, reset, $fell(rsp_valid_ff), $past(rsp_tready))

endmodule
